/* rtl/cfhp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhp_pkg
// Shared types, constants and helpers for the compass heading frame parser.
// ----------------------------------------------------------------------------
package cfhp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h68;
  localparam logic [7:0] CMD_BYTE   = 8'h84;
  localparam logic [3:0] SIGN_NEG   = 4'h1;
  localparam int         HDR_POS    = 0;
  localparam int         CMD_POS    = 3;
  localparam int         HEAD_POS   = 10;

  localparam int         QDEPTH     = 2;
  localparam int         QAW        = 1;
  localparam int         QCW        = 2;

  localparam int         HEAD_W     = 19;
  localparam int         YAW_W      = 16;
  localparam int         MAG_W      = 18;
  localparam int         WRAP_W     = 20;
  localparam int         WRAP_EDGES = 10;

  // thresholds at odd multiples of a half turn, ascending
  localparam logic signed [WRAP_W-1:0] WRAP_EDGE [WRAP_EDGES] = '{
    -20'sd162000, -20'sd126000, -20'sd90000, -20'sd54000, -20'sd18000,
     20'sd18000,   20'sd54000,   20'sd90000,  20'sd126000, 20'sd162000
  };
  localparam logic signed [WRAP_W:0] QUARTER_TURN = 21'sd9000;
  localparam logic signed [WRAP_W:0] WRAP_BIAS    = 21'sd180000;
  localparam logic        [WRAP_W-1:0] FULL_TURN  = 20'd36000;

  // raw heading bytes captured from a matched frame
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } head_raw_t;

  // two bcd digits, nibbles taken at face value
  function automatic logic [7:0] bcd_pair(input logic [7:0] v);
    return 8'({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
  endfunction

endpackage

/* rtl/cfhp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhp_front
// Byte window with fill count; detects header and command, hands off frames.
// ----------------------------------------------------------------------------
module cfhp_front #(
  parameter int FRAME_BYTES = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  output logic                push_valid,
  input  logic                push_ready,
  output cfhp_pkg::head_raw_t push_data
);

  localparam int WIN = FRAME_BYTES - 1;
  localparam int FW  = $clog2(FRAME_BYTES + 1);

  // holds the newest FRAME_BYTES-1 bytes, oldest at index 0
  logic [7:0]    win_r [WIN];
  logic [FW-1:0] fill_r, fill_nxt;
  logic          accept;
  logic          full;
  logic          match;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (fill_r == FW'(WIN));
  assign match    = full && (win_r[cfhp_pkg::HDR_POS] == cfhp_pkg::HDR_BYTE)
                         && (win_r[cfhp_pkg::CMD_POS] == cfhp_pkg::CMD_BYTE);

  assign push_valid   = accept && match;
  assign push_data.b0 = win_r[cfhp_pkg::HEAD_POS];
  assign push_data.b1 = win_r[cfhp_pkg::HEAD_POS + 1];
  assign push_data.b2 = win_r[cfhp_pkg::HEAD_POS + 2];

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (match) begin
        fill_nxt = '0;
      end else if (!full) begin
        fill_nxt = fill_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN-1] <= in_data_byte;
    end
  end

endmodule

/* rtl/cfhp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhp_queue
// Two-entry queue of matched frames between the window and the decoder.
// ----------------------------------------------------------------------------
module cfhp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  cfhp_pkg::head_raw_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output cfhp_pkg::head_raw_t pop_data
);

  cfhp_pkg::head_raw_t           q_r [cfhp_pkg::QDEPTH];
  logic [cfhp_pkg::QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [cfhp_pkg::QCW-1:0]      count_r, count_nxt;
  logic                          push, pop;

  assign push_ready = (count_r != cfhp_pkg::QCW'(cfhp_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = q_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + cfhp_pkg::QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - cfhp_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + cfhp_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cfhp_pkg::QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  // pointers coincide whenever the queue is full or empty
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == cfhp_pkg::QCW'(cfhp_pkg::QDEPTH)) || (count_r == '0) |->
      (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cfhp_pkg::QCW'(cfhp_pkg::QDEPTH))
    else $error("queue count overflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + cfhp_pkg::QCW'(1))
    else $error("queue count did not advance on push");
`endif

endmodule

/* rtl/cfhp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhp_back
// Two-stage decoder: bcd heading, then yaw wrapped to within a half turn.
// ----------------------------------------------------------------------------
module cfhp_back (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  cfhp_pkg::head_raw_t                     in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [cfhp_pkg::HEAD_W-1:0]      out_heading_centideg,
  output logic signed [cfhp_pkg::YAW_W-1:0]       out_enu_yaw_centideg
);

  localparam int CW = $clog2(cfhp_pkg::WRAP_EDGES + 1);

  logic                                  s1_valid_r, s2_valid_r;
  logic                                  s1_ready, s2_ready;
  logic signed [cfhp_pkg::HEAD_W-1:0]    s1_head_r, s2_head_r;
  logic signed [cfhp_pkg::YAW_W-1:0]     s2_yaw_r;

  logic [cfhp_pkg::MAG_W-1:0]            mag;
  logic signed [cfhp_pkg::HEAD_W-1:0]    head_nxt;
  logic signed [cfhp_pkg::WRAP_W-1:0]    x;
  logic [CW-1:0]                         cnt;
  logic signed [cfhp_pkg::WRAP_W:0]      ysum;
  logic [cfhp_pkg::WRAP_W-1:0]           turns;

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  assign out_valid            = s2_valid_r;
  assign out_heading_centideg = s2_head_r;
  assign out_enu_yaw_centideg = s2_yaw_r;

  // stage 1: bcd to binary with sign
  always_comb begin
    mag = cfhp_pkg::MAG_W'(in_data.b0[3:0]) * cfhp_pkg::MAG_W'(10000)
        + cfhp_pkg::MAG_W'(cfhp_pkg::bcd_pair(in_data.b1)) * cfhp_pkg::MAG_W'(100)
        + cfhp_pkg::MAG_W'(cfhp_pkg::bcd_pair(in_data.b2));
    if (in_data.b0[7:4] == cfhp_pkg::SIGN_NEG) begin
      head_nxt = -$signed({1'b0, mag});
    end else begin
      head_nxt = $signed({1'b0, mag});
    end
  end

  // stage 2: yaw = quarter turn - heading, folded by counting crossed edges
  always_comb begin
    x   = cfhp_pkg::WRAP_W'(cfhp_pkg::QUARTER_TURN - (cfhp_pkg::WRAP_W + 1)'(s1_head_r));
    cnt = '0;
    for (int j = 0; j < cfhp_pkg::WRAP_EDGES; j++) begin
      if (x > cfhp_pkg::WRAP_EDGE[j]) begin
        cnt = cnt + CW'(1);
      end
    end
    turns = cfhp_pkg::WRAP_W'(cnt) * cfhp_pkg::FULL_TURN;
    ysum  = (cfhp_pkg::WRAP_W + 1)'(x) + cfhp_pkg::WRAP_BIAS - $signed({1'b0, turns});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_head_r <= head_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_head_r <= s1_head_r;
      s2_yaw_r  <= ysum[cfhp_pkg::YAW_W-1:0];
    end
  end

endmodule

/* rtl/compass_frame_heading_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_frame_heading_parser
// Scans a compass byte stream for heading frames and reports heading and yaw.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one serial byte per transaction (valid/ready). A byte is taken
//           every cycle while the frame queue has room.
//   out_* : one transaction per matched frame: the signed heading and the
//           ENU yaw, both in hundredths of a degree, yaw in (-18000, 18000].
//   A frame is matched when the last FRAME_BYTES bytes start with the header
//   and carry the command at offset three; the window then empties.
//   The last byte of a frame is accepted into the frame queue, then the
//   frame moves to the bcd decode stage, then to the yaw stage, whose
//   registers hold the result.
//   Throughput: one byte per cycle while the frame queue has room.
//   When out_ready is low the two decode stages and the two-entry frame
//   queue fill, after which in_ready drops; no transaction is lost.
//   Reset (rst_n low, synchronous) empties the window, queue and pipeline.
// ----------------------------------------------------------------------------
module compass_frame_heading_parser #(
  parameter int FRAME_BYTES = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cfhp_pkg::HEAD_W-1:0]  out_heading_centideg,
  output logic signed [cfhp_pkg::YAW_W-1:0]   out_enu_yaw_centideg
);

  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;
  cfhp_pkg::head_raw_t push_data, pop_data;

  cfhp_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  cfhp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cfhp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (pop_valid),
    .in_ready             (pop_ready),
    .in_data              (pop_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_heading_centideg (out_heading_centideg),
    .out_enu_yaw_centideg (out_enu_yaw_centideg)
  );

`ifndef ASSERT_OFF
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_enu_yaw_centideg > -16'sd18000) &&
                  (out_enu_yaw_centideg <= 16'sd18000))
    else $error("yaw outside half turn");
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_centideg >= -19'sd166665) &&
                  (out_heading_centideg <= 19'sd166665))
    else $error("heading outside bcd range");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

/* test/tb_compass_frame_heading_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compass_frame_heading_parser
// Self-checking bench for the compass heading frame parser. A byte-window
// predictor tracks every accepted byte and queues the heading and yaw that a
// matched frame must produce. Results are compared field by field in order.
// The byte stream is a mix of directed corner frames, well-formed random
// frames, truncated or corrupt frames and noise. It runs under several
// sender and receiver idle patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_compass_frame_heading_parser;

  localparam int FRAME_BYTES     = 14;
  localparam int QTR_TURN_CD     = 9000;
  localparam int HALF_TURN_CD    = 18000;
  localparam int FULL_TURN_CD    = 36000;
  localparam int BYTES_PER_PHASE = 375;
  localparam int LONG_HOLD       = 200;
  localparam int END_SLACK       = 20;
  localparam int WATCHDOG_CYCLES = 5000;

  typedef struct {
    logic signed [cfhp_pkg::HEAD_W-1:0] heading;
    logic signed [cfhp_pkg::YAW_W-1:0]  yaw;
  } heading_result_t;

  class heading_scoreboard;
    logic [7:0]      window [FRAME_BYTES];
    int              fill;
    heading_result_t heading_q [$];
    int              errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int digit_pair(logic [7:0] v);
      return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    function int pending();
      return heading_q.size();
    endfunction

    // advance the window by one accepted byte
    function void note_byte(logic [7:0] b);
      int              mag;
      int              heading;
      int              wrapped;
      heading_result_t r;
      window[fill] = b;
      fill++;
      if (fill < FRAME_BYTES) return;
      if (window[cfhp_pkg::HDR_POS] == cfhp_pkg::HDR_BYTE &&
          window[cfhp_pkg::CMD_POS] == cfhp_pkg::CMD_BYTE) begin
        mag = int'(window[cfhp_pkg::HEAD_POS][3:0]) * 10000
              + digit_pair(window[cfhp_pkg::HEAD_POS+1]) * 100
              + digit_pair(window[cfhp_pkg::HEAD_POS+2]);
        heading = (window[cfhp_pkg::HEAD_POS][7:4] == cfhp_pkg::SIGN_NEG) ? -mag : mag;
        // wrap into (-half turn, half turn]
        wrapped = (QTR_TURN_CD - heading + HALF_TURN_CD) % FULL_TURN_CD;
        if (wrapped <= 0) wrapped += FULL_TURN_CD;
        r.heading = cfhp_pkg::HEAD_W'(heading);
        r.yaw     = cfhp_pkg::YAW_W'(wrapped - HALF_TURN_CD);
        heading_q.insert(heading_q.size(), r);
        fill = 0;
      end else begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) window[i] = window[i+1];
        fill = FRAME_BYTES - 1;
      end
    endfunction

    function void check_result(logic signed [cfhp_pkg::HEAD_W-1:0] heading,
                               logic signed [cfhp_pkg::YAW_W-1:0] yaw);
      heading_result_t e;
      if (heading_q.size() == 0) begin
        $display("%0t: unexpected result heading %0d yaw %0d", $time, heading, yaw);
        errors++;
        return;
      end
      e = heading_q[0];
      heading_q.delete(0);
      if (heading !== e.heading) begin
        $display("%0t: heading mismatch expected %0d actual %0d", $time, e.heading, heading);
        errors++;
      end
      if (yaw !== e.yaw) begin
        $display("%0t: yaw mismatch expected %0d actual %0d", $time, e.yaw, yaw);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [7:0]                          in_data_byte = 8'h00;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [cfhp_pkg::HEAD_W-1:0]  out_heading_centideg;
  logic signed [cfhp_pkg::YAW_W-1:0]   out_enu_yaw_centideg;

  heading_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int bytes_offered = 0;
  int quiet_cycles  = 0;
  int send_plan [4] = '{0, 69, 0, 30};
  int stall_plan [4] = '{0, 0, 69, 30};

  compass_frame_heading_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_heading_centideg(out_heading_centideg),
    .out_enu_yaw_centideg(out_enu_yaw_centideg)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data_byte);
      if (out_valid && out_ready) sb.check_result(out_heading_centideg, out_enu_yaw_centideg);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("FAIL compass_frame_heading_parser");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    bytes_offered++;
    do @(posedge clk); while (!in_ready);
  endtask

  // first len bytes of a frame with random filler
  task automatic send_frame(input logic [7:0] hdr, cmd, h0, h1, h2, input int len);
    logic [7:0] frame [FRAME_BYTES];
    for (int i = 0; i < FRAME_BYTES; i++) frame[i] = 8'($urandom_range(255));
    frame[cfhp_pkg::HDR_POS]    = hdr;
    frame[cfhp_pkg::CMD_POS]    = cmd;
    frame[cfhp_pkg::HEAD_POS]   = h0;
    frame[cfhp_pkg::HEAD_POS+1] = h1;
    frame[cfhp_pkg::HEAD_POS+2] = h2;
    for (int i = 0; i < len; i++) send_byte(frame[i]);
  endtask

  task automatic send_good_frame(input logic [7:0] h0, h1, h2);
    send_frame(cfhp_pkg::HDR_BYTE, cfhp_pkg::CMD_BYTE, h0, h1, h2, FRAME_BYTES);
  endtask

  task automatic send_random_chunk();
    int         pick;
    logic [7:0] h0;
    pick = $urandom_range(99);
    h0   = ($urandom_range(1) == 1) ? {cfhp_pkg::SIGN_NEG, 4'($urandom_range(15))}
                                    : 8'($urandom_range(255));
    if (pick < 70) begin
      send_good_frame(h0, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(255)));
    end else if (pick < 90) begin
      send_frame(cfhp_pkg::HDR_BYTE, cfhp_pkg::CMD_BYTE, h0, 8'($urandom_range(255)),
                 8'($urandom_range(255)), $urandom_range(1, FRAME_BYTES - 1));
    end else if (pick < 95) begin
      send_frame(cfhp_pkg::HDR_BYTE, 8'($urandom_range(255)) ^ cfhp_pkg::CMD_BYTE,
                 h0, 8'h00, 8'h00, FRAME_BYTES);
    end else begin
      send_frame(8'($urandom_range(255)), cfhp_pkg::CMD_BYTE, h0, 8'h00, 8'h00,
                 FRAME_BYTES);
    end
  endtask

  // hold input low until every queued heading has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the monitor see the last accepted byte first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_plan[p];
      stall_pct     = stall_plan[p];
      bytes_offered = 0;
      if (p == 0) begin
        send_good_frame(8'h00, 8'h00, 8'h00);
        send_good_frame(8'h1F, 8'hFF, 8'hFF);
        send_good_frame(8'h0F, 8'hFF, 8'hFF);
        // sign nibble other than the negative code reads as positive
        send_good_frame(8'hF9, 8'h99, 8'h99);
        // yaw edges around the half turn
        send_good_frame(8'h02, 8'h70, 8'h00);
        send_good_frame(8'h10, 8'h90, 8'h00);
        send_good_frame(8'h02, 8'h70, 8'h01);
        send_good_frame(8'h1F, 8'h30, 8'h00);
        // non-decimal nibbles taken at face value
        send_good_frame(8'h1A, 8'hAB, 8'hF0);
        // header with wrong command, then a stray header before a real frame
        send_frame(cfhp_pkg::HDR_BYTE, cfhp_pkg::CMD_BYTE ^ 8'h01, 8'h00, 8'h00, 8'h00,
                   FRAME_BYTES);
        send_byte(cfhp_pkg::HDR_BYTE);
        send_good_frame(8'h01, 8'h23, 8'h45);
        // long receiver hold-off while frames keep coming
        hold_requests++;
        repeat (6) send_good_frame(8'($urandom_range(255)), 8'h12, 8'h34);
      end
      while (bytes_offered < BYTES_PER_PHASE) send_random_chunk();
      wait_drained();
    end

    repeat (END_SLACK) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS compass_frame_heading_parser");
    end else begin
      $display("FAIL compass_frame_heading_parser");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cfhp_pkg.sv
rtl/cfhp_front.sv
rtl/cfhp_queue.sv
rtl/cfhp_back.sv
rtl/compass_frame_heading_parser.sv
test/tb_compass_frame_heading_parser.sv
